// ----- hdl/fccd_pkg.sv -----
`default_nettype none
package fccd_pkg;
  localparam int FAT_ENTRIES = 256;
  localparam int FAT_AW = $clog2(FAT_ENTRIES);
  localparam int DIR_ENTRIES = 4;
  localparam int DIR_AW = 2;
  localparam int CLUSTER_SHIFT = 2;
  localparam logic [15:0] END_MARK = 16'hFFF8;
  localparam logic [11:0] BASE_YEAR = 12'd1980;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_WALK = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_DIR_FULL = 3'd1;
  localparam logic [2:0] ST_NO_SPACE = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_PAST_END = 3'd4;
endpackage
`default_nettype wire

// ----- hdl/fccd_ram.sv -----
`default_nettype none
module fccd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hdl/fat_cluster_chain_directory.sv -----
// create does a free count pass over clusters 2..255, then a link pass from cluster 2 that
// stops at the last needed cluster, then the end mark write; delete and walk follow the chain
// link by link; one command at a time, busy high while working; the fat ram has one read and
// one write port, one access per cycle.
// reset: a clearing pass writes zero to every fat cell, busy stays high meanwhile.
// the result strobe is high for one cycle; the receiver cannot stall.
`default_nettype none
module fat_cluster_chain_directory
  import fccd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode,
  input  wire logic [63:0] file_name,
  input  wire logic [9:0]  byte_count,
  input  wire logic [11:0] year,
  input  wire logic [3:0]  month,
  input  wire logic [4:0]  day,
  input  wire logic [4:0]  hour,
  input  wire logic [5:0]  minute,
  input  wire logic [5:0]  second,
  input  wire logic [7:0]  chain_position,
  output logic             done,
  output logic [2:0]       status,
  output logic [7:0]       first_cluster,
  output logic [7:0]       cluster_at,
  output logic [15:0]      date_word,
  output logic [15:0]      time_word,
  output logic [9:0]       file_length
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CNT_RD, S_CNT_CHK, S_LNK_RD, S_LNK_CHK, S_MARK, S_CHAIN_RD, S_CHAIN_CHK,
    S_FINISH
  } state_t;

  state_t state;
  logic [1:0] op;
  logic [63:0] nm;
  logic [9:0] blen;
  logic [15:0] dw, tw;
  logic [7:0] pos;
  logic [FAT_AW:0] cur;
  logic [FAT_AW:0] freecnt;
  logic [FAT_AW:0] need;
  logic [FAT_AW-1:0] prev;
  logic have;
  logic [8:0] steps;
  logic [DIR_AW-1:0] ent;

  logic [63:0] e_name [DIR_ENTRIES];
  logic [7:0] e_first [DIR_ENTRIES];
  logic [15:0] e_date [DIR_ENTRIES];
  logic [15:0] e_time [DIR_ENTRIES];
  logic [9:0] e_len [DIR_ENTRIES];

  logic we;
  logic [FAT_AW-1:0] waddr, raddr;
  logic [15:0] wdata, rdata;

  fccd_ram #(.WIDTH(16), .DEPTH(FAT_ENTRIES)) u_fat (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // directory lookups (small register array, fixed fan-in)
  logic free_hit, find_hit;
  logic [DIR_AW-1:0] free_idx, find_idx;
  always_comb begin
    free_hit = 1'b0;
    free_idx = '0;
    find_hit = 1'b0;
    find_idx = '0;
    for (int i = DIR_ENTRIES - 1; i >= 0; i--) begin
      if (e_name[i][7:0] == 8'd0) begin
        free_hit = 1'b1;
        free_idx = DIR_AW'(i);
      end
      if (e_name[i][7:0] != 8'd0 && e_name[i] == file_name) begin
        find_hit = 1'b1;
        find_idx = DIR_AW'(i);
      end
    end
  end

  logic [11:0] yoff;
  assign yoff = year - BASE_YEAR;
  logic cell_free;
  assign cell_free = (rdata == 16'd0) || (rdata == 16'd1);
  logic [FAT_AW:0] need_in;
  always_comb begin
    need_in = (FAT_AW + 1)'((11'(byte_count) + 11'd3) >> CLUSTER_SHIFT);
    if (need_in == '0) need_in = (FAT_AW + 1)'(1);
  end

  always_comb begin
    raddr = cur[FAT_AW-1:0];
  end

  always_ff @(posedge clk) begin
    we <= 1'b0;
    done <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      busy <= 1'b1;
      cur <= '0;
      for (int i = 0; i < DIR_ENTRIES; i++) begin
        e_name[i] <= '0;
        e_first[i] <= '0;
        e_date[i] <= '0;
        e_time[i] <= '0;
        e_len[i] <= '0;
      end
    end else begin
      case (state)
        S_CLEAR: begin
          we <= 1'b1;
          waddr <= cur[FAT_AW-1:0];
          wdata <= '0;
          cur <= cur + 1'b1;
          if (cur == (FAT_AW + 1)'(FAT_ENTRIES - 1)) begin
            state <= S_IDLE;
            busy <= 1'b0;
          end
        end
        S_IDLE: begin
          if (start) begin
            op <= opcode;
            nm <= file_name;
            blen <= byte_count;
            pos <= chain_position;
            dw <= {yoff[6:0], month, day};
            tw <= {hour, minute, second[5:1]};
            need <= need_in;
            freecnt <= '0;
            have <= 1'b0;
            steps <= '0;
            busy <= 1'b1;
            status <= ST_NOT_FOUND;
            first_cluster <= '0;
            cluster_at <= '0;
            date_word <= '0;
            time_word <= '0;
            file_length <= '0;
            state <= S_FINISH;
            if (file_name[7:0] != 8'd0) begin
              case (opcode)
                OP_CREATE: begin
                  if (!free_hit) status <= ST_DIR_FULL;
                  else begin
                    ent <= free_idx;
                    cur <= (FAT_AW + 1)'(2);
                    state <= S_CNT_RD;
                  end
                end
                OP_DELETE, OP_WALK: begin
                  if (find_hit) begin
                    ent <= find_idx;
                    status <= ST_OK;
                    first_cluster <= e_first[find_idx];
                    date_word <= e_date[find_idx];
                    time_word <= e_time[find_idx];
                    file_length <= e_len[find_idx];
                    cur <= (FAT_AW + 1)'(e_first[find_idx]);
                    state <= S_CHAIN_RD;
                    if (opcode == OP_WALK && chain_position == 8'd0) state <= S_CHAIN_CHK;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        S_CNT_RD: state <= S_CNT_CHK;
        S_CNT_CHK: begin
          if (cell_free) freecnt <= freecnt + 1'b1;
          if (cur == (FAT_AW + 1)'(FAT_ENTRIES - 1)) begin
            if (need > freecnt + (FAT_AW + 1)'(cell_free)) begin
              status <= ST_NO_SPACE;
              state <= S_FINISH;
            end else begin
              cur <= (FAT_AW + 1)'(2);
              state <= S_LNK_RD;
            end
          end else begin
            cur <= cur + 1'b1;
            state <= S_CNT_RD;
          end
        end
        S_LNK_RD: state <= S_LNK_CHK;
        S_LNK_CHK: begin
          // link writes go behind the scan, so no read sees a stale cell
          if (cell_free) begin
            if (have) begin
              we <= 1'b1;
              waddr <= prev;
              wdata <= 16'(cur);
            end else first_cluster <= cur[7:0];
            have <= 1'b1;
            prev <= cur[FAT_AW-1:0];
          end
          if (cell_free && need == (FAT_AW + 1)'(1)) begin
            state <= S_MARK;
            status <= ST_OK;
            e_name[ent] <= nm;
            e_first[ent] <= have ? first_cluster : cur[7:0];
            e_date[ent] <= dw;
            e_time[ent] <= tw;
            e_len[ent] <= blen;
            date_word <= dw;
            time_word <= tw;
            file_length <= blen;
            cluster_at <= have ? first_cluster : cur[7:0];
            if (!have) first_cluster <= cur[7:0];
          end else begin
            cur <= cur + 1'b1;
            state <= S_LNK_RD;
          end
          if (cell_free) need <= need - 1'b1;
        end
        S_MARK: begin
          // last cluster of the new chain gets the end mark
          we <= 1'b1;
          waddr <= prev;
          wdata <= END_MARK;
          state <= S_FINISH;
        end
        S_CHAIN_RD: state <= S_CHAIN_CHK;
        S_CHAIN_CHK: begin
          if (op == OP_DELETE) begin
            we <= 1'b1;
            waddr <= cur[FAT_AW-1:0];
            wdata <= 16'd1;
            if (rdata >= END_MARK || rdata >= 16'(FAT_ENTRIES)
                || steps == 9'(FAT_ENTRIES - 1)) begin
              state <= S_FINISH;
              e_name[ent] <= '0;
              e_first[ent] <= '0;
              e_date[ent] <= '0;
              e_time[ent] <= '0;
              e_len[ent] <= '0;
            end else begin
              cur <= rdata[FAT_AW:0];
              steps <= steps + 1'b1;
              state <= S_CHAIN_RD;
            end
          end else begin
            // walk: cur holds cluster after steps links
            if (steps == 9'(pos)) begin
              if (cur >= (FAT_AW + 1)'(FAT_ENTRIES)) status <= ST_PAST_END;
              else cluster_at <= cur[7:0];
              state <= S_FINISH;
            end else if (cur >= (FAT_AW + 1)'(FAT_ENTRIES)) begin
              status <= ST_PAST_END;
              state <= S_FINISH;
            end else begin
              cur <= (rdata >= 16'(FAT_ENTRIES)) ? (FAT_AW + 1)'(FAT_ENTRIES)
                                                  : rdata[FAT_AW:0];
              steps <= steps + 1'b1;
              state <= S_CHAIN_RD;
            end
          end
        end
        S_FINISH: begin
          done <= 1'b1;
          busy <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- sim/fccd_checker.sv -----
module fccd_checker
  import fccd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  opcode,
  input  wire logic [63:0] file_name,
  input  wire logic [9:0]  byte_count,
  input  wire logic [11:0] year,
  input  wire logic [3:0]  month,
  input  wire logic [4:0]  day,
  input  wire logic [4:0]  hour,
  input  wire logic [5:0]  minute,
  input  wire logic [5:0]  second,
  input  wire logic [7:0]  chain_position,
  input  wire logic        done,
  input  wire logic [2:0]  status,
  input  wire logic [7:0]  first_cluster,
  input  wire logic [7:0]  cluster_at,
  input  wire logic [15:0] date_word,
  input  wire logic [15:0] time_word,
  input  wire logic [9:0]  file_length,
  output int               fail_count,
  output int               pending,
  output int               results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  first_cluster;
    logic [7:0]  cluster_at;
    logic [15:0] date_word;
    logic [15:0] time_word;
    logic [9:0]  file_length;
  } dir_reply_t;

  logic [15:0] fat_mirror [FAT_ENTRIES];
  logic [63:0] name_mirror [DIR_ENTRIES];
  logic [7:0]  first_mirror [DIR_ENTRIES];
  logic [15:0] date_mirror [DIR_ENTRIES];
  logic [15:0] time_mirror [DIR_ENTRIES];
  logic [9:0]  len_mirror [DIR_ENTRIES];
  dir_reply_t  expected_replies [$];

  assign pending = expected_replies.size();

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic int lookup_file(input logic [63:0] nm);
    if (nm[7:0] == 8'd0) return -1;
    for (int i = 0; i < DIR_ENTRIES; i++)
      if (name_mirror[i][7:0] != 8'd0 && name_mirror[i] == nm) return i;
    return -1;
  endfunction

  function automatic dir_reply_t info_of(input int e);
    dir_reply_t r;
    r = '0;
    r.first_cluster = first_mirror[e];
    r.date_word = date_mirror[e];
    r.time_word = time_mirror[e];
    r.file_length = len_mirror[e];
    return r;
  endfunction

  function automatic dir_reply_t apply_command();
    dir_reply_t r;
    int e, freecnt, need, prev, first, c, k;
    logic [15:0] nx;
    r = '0;
    e = -1;
    if (opcode == OP_CREATE) begin
      if (file_name[7:0] == 8'd0) begin
        r.status = ST_NOT_FOUND;
        return r;
      end
      for (int i = 0; i < DIR_ENTRIES; i++)
        if (e < 0 && name_mirror[i][7:0] == 8'd0) e = i;
      if (e < 0) begin
        r.status = ST_DIR_FULL;
        return r;
      end
      freecnt = 0;
      for (int i = 2; i < FAT_ENTRIES; i++)
        if (fat_mirror[i] <= 16'd1) freecnt++;
      need = (int'(byte_count) + 3) / 4;
      if (need == 0) need = 1;
      if (need > freecnt) begin
        r.status = ST_NO_SPACE;
        return r;
      end
      prev = -1;
      first = 0;
      for (int i = 2; i < FAT_ENTRIES && need > 0; i++) begin
        if (fat_mirror[i] <= 16'd1) begin
          if (prev >= 0) fat_mirror[prev] = 16'(i);
          else first = i;
          prev = i;
          need--;
        end
      end
      fat_mirror[prev] = END_MARK;
      name_mirror[e] = file_name;
      first_mirror[e] = 8'(first);
      date_mirror[e] = {7'(year - BASE_YEAR), month, day};
      time_mirror[e] = {hour, minute, second[5:1]};
      len_mirror[e] = byte_count;
      r = info_of(e);
      r.cluster_at = 8'(first);
    end else if (opcode == OP_DELETE) begin
      e = lookup_file(file_name);
      if (e < 0) begin
        r.status = ST_NOT_FOUND;
        return r;
      end
      r = info_of(e);
      c = first_mirror[e];
      for (k = 0; k < FAT_ENTRIES && c < FAT_ENTRIES; k++) begin
        nx = fat_mirror[c];
        fat_mirror[c] = 16'd1;
        if (nx >= END_MARK) break;
        c = nx;
      end
      name_mirror[e] = '0;
      first_mirror[e] = '0;
      date_mirror[e] = '0;
      time_mirror[e] = '0;
      len_mirror[e] = '0;
    end else if (opcode == OP_WALK) begin
      e = lookup_file(file_name);
      if (e < 0) begin
        r.status = ST_NOT_FOUND;
        return r;
      end
      r = info_of(e);
      c = first_mirror[e];
      for (k = 0; k < chain_position; k++) begin
        if (c >= FAT_ENTRIES) begin
          r.status = ST_PAST_END;
          return r;
        end
        c = fat_mirror[c];
      end
      if (c >= FAT_ENTRIES) r.status = ST_PAST_END;
      else r.cluster_at = 8'(c);
    end else begin
      r.status = ST_NOT_FOUND;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    dir_reply_t want;
    if (rst) begin
      for (int i = 0; i < FAT_ENTRIES; i++) fat_mirror[i] = '0;
      for (int i = 0; i < DIR_ENTRIES; i++) begin
        name_mirror[i] = '0;
        first_mirror[i] = '0;
        date_mirror[i] = '0;
        time_mirror[i] = '0;
        len_mirror[i] = '0;
      end
      expected_replies.delete();
      fail_count = 0;
      results_seen = 0;
    end else begin
      if (done) begin
        results_seen++;
        if (expected_replies.size() == 0) begin
          $display("unexpected result at %0t, status %0d", $realtime, status);
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          if (status !== want.status) report_mismatch("status", status, want.status);
          if (first_cluster !== want.first_cluster)
            report_mismatch("first_cluster", first_cluster, want.first_cluster);
          if (cluster_at !== want.cluster_at)
            report_mismatch("cluster_at", cluster_at, want.cluster_at);
          if (date_word !== want.date_word)
            report_mismatch("date_word", date_word, want.date_word);
          if (time_word !== want.time_word)
            report_mismatch("time_word", time_word, want.time_word);
          if (file_length !== want.file_length)
            report_mismatch("file_length", file_length, want.file_length);
        end
      end
      if (start && !busy) expected_replies.push_back(apply_command());
    end
  end
endmodule

// ----- sim/tb_fat_cluster_chain_directory.sv -----
module tb_fat_cluster_chain_directory;
  import fccd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 3_000_000;

  logic        clk, rst, start, busy, done;
  logic [1:0]  opcode;
  logic [63:0] file_name;
  logic [9:0]  byte_count;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day, hour;
  logic [5:0]  minute, second;
  logic [7:0]  chain_position;
  logic [2:0]  status;
  logic [7:0]  first_cluster, cluster_at;
  logic [15:0] date_word, time_word;
  logic [9:0]  file_length;
  int          fail_count, pending, results_seen;
  longint      cycles;
  int          creates_sent, deletes_sent, walks_sent;
  logic        no_idle;
  logic [63:0] name_pool [8];

  fat_cluster_chain_directory dut (.*);
  fccd_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // one transaction; start drops only once accepted unless the next follows directly
  task automatic send_cmd(input logic [1:0] op, input logic [63:0] nm, input logic [9:0] bc,
                          input logic [7:0] pos);
    opcode = op;
    file_name = nm;
    byte_count = bc;
    chain_position = pos;
    year = 12'($urandom_range(1980, 2107));
    month = 4'($urandom_range(1, 12));
    day = 5'($urandom_range(1, 31));
    hour = 5'($urandom_range(0, 23));
    minute = 6'($urandom_range(0, 59));
    second = 6'($urandom_range(0, 59));
    if ($urandom_range(0, 9) == 0) begin
      year = 12'($urandom);
      month = 4'($urandom);
      day = 5'($urandom);
      hour = 5'($urandom);
      minute = 6'($urandom);
      second = 6'($urandom);
    end
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    case (op)
      OP_CREATE: creates_sent++;
      OP_DELETE: deletes_sent++;
      default:   walks_sent++;
    endcase
    if (!no_idle && $urandom_range(0, 99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [63:0] pick_name();
    logic [63:0] nm;
    if ($urandom_range(0, 9) < 8) return name_pool[$urandom_range(0, 7)];
    nm = {$urandom, $urandom};
    if ($urandom_range(0, 5) == 0) nm[7:0] = 8'd0;
    return nm;
  endfunction

  function automatic logic [9:0] pick_length();
    case ($urandom_range(0, 9))
      0: return 10'd0;
      1: return 10'd1023;
      2, 3: return 10'($urandom_range(200, 1023));
      default: return 10'($urandom_range(1, 64));
    endcase
  endfunction

  initial begin
    int r;
    start = 1'b0;
    rst = 1'b1;
    opcode = OP_CREATE;
    file_name = '0;
    byte_count = '0;
    year = 12'd1980;
    month = 4'd1;
    day = 5'd1;
    hour = '0;
    minute = '0;
    second = '0;
    chain_position = '0;
    no_idle = 1'b0;
    creates_sent = 0;
    deletes_sent = 0;
    walks_sent = 0;
    for (int i = 0; i < 8; i++) name_pool[i] = {$urandom, $urandom} | 64'h1;
    name_pool[0] = 64'hFFFF_FFFF_FFFF_FFFF;
    name_pool[1] = 64'h0000_0000_0000_0001;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, errors, duplicate names, chain ends
    send_cmd(OP_WALK, name_pool[0], 0, 0);
    send_cmd(OP_DELETE, name_pool[0], 0, 0);
    send_cmd(OP_CREATE, 64'hFF00, 10, 0);
    send_cmd(OP_CREATE, name_pool[0], 0, 0);
    send_cmd(OP_CREATE, name_pool[1], 1023, 0);
    send_cmd(OP_WALK, name_pool[1], 0, 255);
    send_cmd(OP_WALK, name_pool[1], 0, 255);
    send_cmd(OP_WALK, name_pool[0], 0, 0);
    send_cmd(OP_WALK, name_pool[0], 0, 1);
    send_cmd(OP_WALK, name_pool[0], 0, 2);
    send_cmd(OP_CREATE, name_pool[2], 5, 0);
    send_cmd(OP_CREATE, name_pool[2], 4, 0);
    send_cmd(OP_CREATE, name_pool[3], 1, 0);
    send_cmd(OP_WALK, name_pool[2], 0, 1);
    send_cmd(OP_DELETE, name_pool[2], 0, 0);
    send_cmd(OP_WALK, name_pool[2], 0, 0);
    send_cmd(OP_DELETE, name_pool[1], 0, 0);
    send_cmd(OP_CREATE, name_pool[4], 1020, 0);
    send_cmd(OP_CREATE, name_pool[5], 3, 0);
    send_cmd(OP_CREATE, name_pool[6], 3, 0);
    send_cmd(OP_WALK, name_pool[4], 0, 254);
    send_cmd(2'd3, name_pool[0], 0, 0);
    send_cmd(OP_DELETE, 64'h0, 0, 0);
    drain();

    for (int n = 0; n < 1000; n++) begin
      no_idle = (n >= 300 && n < 450);
      if (n == 600) drain();
      r = $urandom_range(0, 99);
      if (r < 35) send_cmd(OP_CREATE, pick_name(), pick_length(), 0);
      else if (r < 60) send_cmd(OP_DELETE, pick_name(), 10'($urandom), 8'($urandom));
      else if (r < 97)
        send_cmd(OP_WALK, pick_name(), 10'($urandom),
                 ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20)));
      else send_cmd(2'd3, pick_name(), 10'($urandom), 8'($urandom));
    end
    drain();

    $display("covered %0d creates, %0d deletes, %0d walks or unknown commands",
             creates_sent, deletes_sent, walks_sent);
    $display("%0d results checked in %0d cycles", results_seen, cycles);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
